FILE: rtl/sparse_label_value_table_defines.svh
// Assertion macros used by the checker file.
`ifndef SPARSE_LABEL_VALUE_TABLE_DEFINES_SVH
`define SPARSE_LABEL_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, off during reset
`define SLVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SLVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after a reset edge
`define SLVT_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

FILE: rtl/slvt_pkg.sv
`default_nettype none
package slvt_pkg;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [10:0] VERTEX_COUNT_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_CMP,
        ST_EXEC,
        ST_WB,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_UPDATE,
        OP_INSERT,
        OP_DELETE
    } t_cell_op;

    typedef struct packed {
        logic     load;
        logic     cmp;
        t_cell_op op;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/slvt_in_if.sv
`default_nettype none
interface slvt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [9:0]  vertex;
    logic [15:0] label;
    logic [15:0] value;

    modport source (output valid, cmd, vertex, label, value, input ready);
    modport sink   (input valid, cmd, vertex, label, value, output ready);
endinterface
`default_nettype wire

FILE: rtl/slvt_out_if.sv
`default_nettype none
interface slvt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic        status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/slvt_ram.sv
`default_nettype none
module slvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/slvt_cell.sv
`default_nettype none
module slvt_cell #(
    parameter int LW = 16,
    parameter int VW = 16
) (
    input  wire logic               i_clk,
    input  wire slvt_pkg::t_cell_ctl i_ctl,
    input  wire logic [LW-1:0]      i_ld_label,
    input  wire logic [VW-1:0]      i_ld_value,
    input  wire logic               i_valid,
    input  wire logic [LW-1:0]      i_key,
    input  wire logic [VW-1:0]      i_val,
    input  wire logic               i_prev_lt,
    input  wire logic [LW-1:0]      i_left_label,
    input  wire logic [VW-1:0]      i_left_value,
    input  wire logic [LW-1:0]      i_right_label,
    input  wire logic [VW-1:0]      i_right_value,
    output logic      [LW-1:0]      o_label,
    output logic      [VW-1:0]      o_value,
    output logic                    o_lt,
    output logic                    o_eq
);
    logic [LW-1:0] r_label;
    logic [VW-1:0] r_value;
    logic          r_lt;
    logic          r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_label <= i_ld_label;
            r_value <= i_ld_value;
        end else begin
            case (i_ctl.op)
                slvt_pkg::OP_UPDATE: begin
                    if (r_eq) begin
                        r_value <= i_val;
                    end
                end
                slvt_pkg::OP_INSERT: begin
                    if (!r_lt) begin
                        if (i_prev_lt) begin
                            r_label <= i_key;
                            r_value <= i_val;
                        end else begin
                            r_label <= i_left_label;
                            r_value <= i_left_value;
                        end
                    end
                end
                slvt_pkg::OP_DELETE: begin
                    if (!r_lt) begin
                        r_label <= i_right_label;
                        r_value <= i_right_value;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.cmp) begin
            r_lt <= i_valid && (r_label < i_key);
            r_eq <= i_valid && (r_label == i_key);
        end
    end

    assign o_label = r_label;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
endmodule
`default_nettype wire

FILE: rtl/sparse_label_value_table.sv
// Per-vertex sorted label/value map. Each vertex list is one row of a single
// memory, loaded into a row of LIST_CAPACITY cells that compare against the
// key in parallel and shift toward a neighbor to insert or delete. A get or
// set steps through read, load, compare, execute, write back and result; the
// result stage waits while the output is stalled. A clear writes
// min(vertex_count, NUM_VERTICES) rows, one row a cycle; other commands and
// out-of-range vertices go straight to the result. After reset a clearing pass
// over all NUM_VERTICES rows runs before the first item is accepted.
`default_nettype none
module sparse_label_value_table #(
    parameter int NUM_VERTICES  = 1024,
    parameter int LIST_CAPACITY = 32,
    parameter int LABEL_WIDTH   = 16,
    parameter int VALUE_WIDTH   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    slvt_in_if.sink          s_in,
    slvt_out_if.source       m_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int AW  = $clog2(NUM_VERTICES);
    localparam int CAP = LIST_CAPACITY;
    localparam int LW  = LABEL_WIDTH;
    localparam int VW  = VALUE_WIDTH;
    localparam int CW  = $clog2(LIST_CAPACITY + 1);
    localparam int RW  = CAP * (LW + VW) + CW;

    slvt_pkg::t_state r_state, n_state;

    logic [10:0]   r_vc;
    logic [1:0]    r_cmd;
    logic [AW-1:0] r_vtx;
    logic [LW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [CW-1:0] r_cnt;
    logic [AW:0]   r_sweep;
    logic [AW:0]   r_lim;
    logic          r_clear;
    logic [15:0]   r_res_value;
    logic          r_res_status;
    logic          r_out_valid;
    logic [15:0]   r_out_value;
    logic          r_out_status;

    logic          w_accept;
    logic          w_in_range;
    logic [31:0]   w_vtx32;
    logic [31:0]   w_key32;
    logic [31:0]   w_val32;
    logic [31:0]   w_lim32;
    logic          w_found;
    logic          w_full;
    logic [VW-1:0] w_hit_value;
    logic [31:0]   w_hit32;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [RW-1:0] w_wdata;
    logic [RW-1:0] w_rdata;
    logic [RW-1:0] w_row;

    slvt_pkg::t_cell_ctl w_ctl;

    logic [LW-1:0] w_label [CAP];
    logic [VW-1:0] w_value [CAP];
    logic          w_lt    [CAP];
    logic          w_eq    [CAP];

    assign w_accept   = s_in.valid && s_in.ready;
    assign w_vtx32    = 32'(s_in.vertex);
    assign w_key32    = 32'(s_in.label);
    assign w_val32    = 32'(s_in.value);
    assign w_in_range = w_vtx32 < 32'(NUM_VERTICES);
    assign w_lim32    = (32'(r_vc) > 32'(NUM_VERTICES)) ? 32'(NUM_VERTICES) : 32'(r_vc);
    assign w_full     = 32'(r_cnt) == 32'(CAP);

    always_comb begin
        w_found     = 1'b0;
        w_hit_value = '0;
        for (int i = 0; i < CAP; i++) begin
            w_found = w_found | w_eq[i];
            if (w_eq[i]) begin
                w_hit_value = w_hit_value | w_value[i];
            end
        end
    end
    assign w_hit32 = 32'(w_hit_value);

    slvt_ram #(.WIDTH(RW), .DEPTH(NUM_VERTICES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_vtx),
        .o_rdata(w_rdata)
    );

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic          w_prev_lt;
        logic [LW-1:0] w_left_label;
        logic [VW-1:0] w_left_value;
        logic [LW-1:0] w_right_label;
        logic [VW-1:0] w_right_value;
        if (g == 0) begin : g_first
            assign w_prev_lt    = 1'b1;
            assign w_left_label = '0;
            assign w_left_value = '0;
        end else begin : g_mid
            assign w_prev_lt    = w_lt[g-1];
            assign w_left_label = w_label[g-1];
            assign w_left_value = w_value[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign w_right_label = '0;
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_label = w_label[g+1];
            assign w_right_value = w_value[g+1];
        end

        slvt_cell #(.LW(LW), .VW(VW)) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_ld_label   (w_rdata[g*LW +: LW]),
            .i_ld_value   (w_rdata[CAP*LW + g*VW +: VW]),
            .i_valid      (32'(g) < 32'(r_cnt)),
            .i_key        (r_key),
            .i_val        (r_val),
            .i_prev_lt    (w_prev_lt),
            .i_left_label (w_left_label),
            .i_left_value (w_left_value),
            .i_right_label(w_right_label),
            .i_right_value(w_right_value),
            .o_label      (w_label[g]),
            .o_value      (w_value[g]),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g])
        );

        assign w_row[g*LW +: LW]          = w_label[g];
        assign w_row[CAP*LW + g*VW +: VW] = w_value[g];
    end
    assign w_row[CAP*(LW+VW) +: CW] = r_cnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            slvt_pkg::ST_SWEEP: begin
                if (r_sweep >= r_lim) begin
                    n_state = r_clear ? slvt_pkg::ST_DONE : slvt_pkg::ST_IDLE;
                end
            end
            slvt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (s_in.cmd == slvt_pkg::CMD_CLEAR) begin
                        n_state = slvt_pkg::ST_SWEEP;
                    end else if ((s_in.cmd == slvt_pkg::CMD_GET ||
                                  s_in.cmd == slvt_pkg::CMD_SET) && w_in_range) begin
                        n_state = slvt_pkg::ST_READ;
                    end else begin
                        n_state = slvt_pkg::ST_DONE;
                    end
                end
            end
            slvt_pkg::ST_READ: n_state = slvt_pkg::ST_LOAD;
            slvt_pkg::ST_LOAD: n_state = slvt_pkg::ST_CMP;
            slvt_pkg::ST_CMP:  n_state = slvt_pkg::ST_EXEC;
            slvt_pkg::ST_EXEC: n_state = slvt_pkg::ST_WB;
            slvt_pkg::ST_WB:   n_state = slvt_pkg::ST_DONE;
            slvt_pkg::ST_DONE: begin
                if (!r_out_valid || m_out.ready) begin
                    n_state = slvt_pkg::ST_IDLE;
                end
            end
            default: n_state = slvt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_in.ready = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_vtx;
        w_wdata    = w_row;
        w_ctl      = '{load: 1'b0, cmp: 1'b0, op: slvt_pkg::OP_HOLD};
        case (r_state)
            slvt_pkg::ST_SWEEP: begin
                w_we    = r_sweep < r_lim;
                w_waddr = r_sweep[AW-1:0];
                w_wdata = '0;
            end
            slvt_pkg::ST_IDLE: s_in.ready = 1'b1;
            slvt_pkg::ST_LOAD: w_ctl.load = 1'b1;
            slvt_pkg::ST_CMP:  w_ctl.cmp = 1'b1;
            slvt_pkg::ST_EXEC: begin
                if (r_cmd == slvt_pkg::CMD_SET) begin
                    if (r_val != '0) begin
                        if (w_found) begin
                            w_ctl.op = slvt_pkg::OP_UPDATE;
                        end else if (!w_full) begin
                            w_ctl.op = slvt_pkg::OP_INSERT;
                        end
                    end else if (w_found) begin
                        w_ctl.op = slvt_pkg::OP_DELETE;
                    end
                end
            end
            slvt_pkg::ST_WB: w_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slvt_pkg::ST_SWEEP;
            r_sweep     <= '0;
            r_lim       <= (AW+1)'(NUM_VERTICES);
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
            r_vc        <= slvt_pkg::VERTEX_COUNT_RESET;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2] == slvt_pkg::REG_VERTEX_COUNT) begin
                r_vc <= pwdata[10:0];
            end
            if (r_state == slvt_pkg::ST_SWEEP && r_sweep < r_lim) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (w_accept && s_in.cmd == slvt_pkg::CMD_CLEAR) begin
                r_sweep <= '0;
                r_lim   <= w_lim32[AW:0];
                r_clear <= 1'b1;
            end
            if (r_state == slvt_pkg::ST_DONE && (!r_out_valid || m_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= s_in.cmd;
            r_vtx        <= w_vtx32[AW-1:0];
            r_key        <= w_key32[LW-1:0];
            r_val        <= w_val32[VW-1:0];
            r_res_value  <= '0;
            r_res_status <= 1'b0;
        end
        if (r_state == slvt_pkg::ST_LOAD) begin
            r_cnt <= w_rdata[CAP*(LW+VW) +: CW];
        end
        if (r_state == slvt_pkg::ST_EXEC) begin
            if (r_cmd == slvt_pkg::CMD_GET) begin
                r_res_value <= w_found ? w_hit32[15:0] : 16'd0;
            end else if (r_val != '0) begin
                if (!w_found && w_full) begin
                    r_res_status <= 1'b1;
                end else if (!w_found) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (w_found) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (r_state == slvt_pkg::ST_DONE && (!r_out_valid || m_out.ready)) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign m_out.valid      = r_out_valid;
    assign m_out.read_value = r_out_value;
    assign m_out.status     = r_out_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == slvt_pkg::REG_VERTEX_COUNT) ? 32'(r_vc) : 32'd0;
endmodule
`default_nettype wire

FILE: rtl/slvt_checker.sv
`default_nettype none
`include "sparse_label_value_table_defines.svh"
module slvt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_out_value,
    input wire logic        i_out_status
);
    `SLVT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `SLVT_ASSERT_NXT(a_in_single, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "second item taken while busy")
    `SLVT_ASSERT_IMP(a_drop_zero, i_clk, i_rst_n, i_out_valid && i_out_status, i_out_value == 16'd0, "dropped insert with value")
    `SLVT_ASSERT_RST(a_rst_idle, i_clk, i_rst_n, !i_out_valid && !i_in_ready, "activity right after reset")
endmodule

bind sparse_label_value_table slvt_checker u_slvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_in.valid),
    .i_in_ready  (s_in.ready),
    .i_out_valid (m_out.valid),
    .i_out_ready (m_out.ready),
    .i_out_value (m_out.read_value),
    .i_out_status(m_out.status)
);
`default_nettype wire
